### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the keyword parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCKP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCKP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sckp_pkg.sv
// ----------------------------------------------------------------------------
// sckp_pkg
// Types, character codes and keyword tables of the serial keyword parser.
// ----------------------------------------------------------------------------
package sckp_pkg;

  localparam int BUFFER_DEPTH = 15;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH);
  localparam int KEY_COUNT    = 6;
  localparam int KEY_MAX      = 10;
  localparam int KIDX_W       = $clog2(KEY_MAX);
  localparam int CMD_W        = 3;

  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Keyword text, leading '@' included, zero padded.
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX] = '{
    '{8'h40, 8'h72, 8'h67, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h40, 8'h6C, 8'h63, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h40, 8'h72, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h40, 8'h72, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h4F, 8'h46, 8'h46, 8'h00},
    '{8'h40, 8'h6D, 8'h6F, 8'h74, 8'h6F, 8'h72, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h40, 8'h6D, 8'h6F, 8'h74, 8'h6F, 8'h72, 8'h4F, 8'h46, 8'h46, 8'h00}
  };

  localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd4, 4'd4, 4'd8, 4'd9, 4'd8, 4'd9};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_SCAN,
    ST_FINISH
  } sckp_state_t;

  // Control for one step of the compare and fold unit.
  typedef struct packed {
    logic clr;
    logic vld;
  } sckp_step_t;

  function automatic logic [7:0] key_char(input logic [CMD_W-1:0] k,
                                          input logic [CNT_W-1:0] j);
    logic [7:0] c;
    c = 8'h00;
    if (j < CNT_W'(KEY_MAX)) begin
      c = KEY_TEXT[k][j[KIDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

### rtl/sckp_match.sv
// ----------------------------------------------------------------------------
// sckp_match
// Compares stored bytes against the keywords and folds the decimal argument.
// ----------------------------------------------------------------------------
module sckp_match (
  input  logic                       clk,
  input  sckp_pkg::sckp_step_t       ctl,
  input  logic [7:0]                 byte_in,
  input  logic [sckp_pkg::CNT_W-1:0] idx,
  input  logic [sckp_pkg::CNT_W-1:0] split,
  input  logic                       dash,
  output logic                       found,
  output logic [sckp_pkg::CMD_W-1:0] command,
  output logic [7:0]                 argument
);
  import sckp_pkg::*;

  logic [KEY_COUNT-1:0] mask_r, mask_nxt;
  logic [7:0]           arg_r, arg_nxt;
  logic [KEY_COUNT-1:0] hit;

  always_comb begin
    mask_nxt = mask_r;
    arg_nxt  = arg_r;
    if (ctl.clr) begin
      mask_nxt = '1;
      arg_nxt  = '0;
    end else if (ctl.vld) begin
      if (idx < split) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (byte_in != key_char(CMD_W'(k), idx)) begin
            mask_nxt[k] = 1'b0;
          end
        end
      end else if (idx > split) begin
        // arg * 10 as two shifts, then add the digit, all modulo 256.
        arg_nxt = {arg_r[4:0], 3'b000} + {arg_r[6:0], 1'b0} + byte_in - CH_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    arg_r  <= arg_nxt;
  end

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      hit[k] = mask_r[k] && (CNT_W'(KEY_LEN[k]) == split);
    end
    found   = dash && (|hit);
    command = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (dash && hit[k]) begin
        command = CMD_W'(k);
      end
    end
    argument = dash ? arg_r : 8'h00;
  end

endmodule

### rtl/serial_command_keyword_parser.sv
// ----------------------------------------------------------------------------
// serial_command_keyword_parser
// Collects '@'-framed serial messages and decodes keyword and argument.
// ----------------------------------------------------------------------------
// Result: once the transfer that ends a message is taken, the stored bytes
//   (at most 14) are scanned and the result then goes to the output register.
// Throughput: one byte per cycle while a message is collected; the input is
//   then held off while the message memory is scanned and the result is loaded.
// Reset: rst_n is synchronous and active low; the block returns to idle,
//   waiting for '@', with no result pending.
`include "assert_macros.svh"

module serial_command_keyword_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [sckp_pkg::CMD_W-1:0] out_command,
  output logic [7:0]                 out_argument
);
  import sckp_pkg::*;

  // Count value at which the store counts as full and the message ends.
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_DEPTH - 1);

  sckp_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] split_r, split_nxt;
  logic             dash_r, dash_nxt;

  // Scan pipeline: read address, then the registered read data with its index.
  logic [CNT_W-1:0] rd_addr_r;
  logic             p_vld_r;
  logic [CNT_W-1:0] p_idx_r;
  logic [7:0]       rd_data_r;

  logic [7:0]       mem [BUFFER_DEPTH];

  logic             accept;
  logic             is_at, is_hash, is_dash;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  logic             scan_clr;
  logic             issue;
  logic             load_out;

  logic             m_found;
  logic [CMD_W-1:0] m_command;
  logic [7:0]       m_argument;
  sckp_step_t       step;

  logic             out_valid_r;
  logic             out_found_r;
  logic [CMD_W-1:0] out_command_r;
  logic [7:0]       out_argument_r;

  assign accept  = in_valid && in_ready;
  assign is_at   = (in_rx_byte == CH_AT);
  assign is_hash = (in_rx_byte == CH_HASH);
  assign is_dash = (in_rx_byte == CH_DASH);

  // Next state. A message ends on '#' or when the byte being stored fills
  // the store. The scan ends once every stored byte has been read and the
  // last read has been consumed by the match unit.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_at) begin
          state_nxt = ST_RECV;
        end
      end
      ST_RECV: begin
        if (accept && (is_hash || (cnt_r == CNT_LAST - 1'b1))) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_addr_r == cnt_r) && !p_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs. Input is taken only while collecting, so the memory is
  // never written and scanned at the same time and needs no forwarding.
  always_comb begin
    in_ready = 1'b0;
    scan_clr = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE, ST_RECV: begin
        in_ready = 1'b1;
        scan_clr = 1'b1;
      end
      ST_SCAN: begin
        issue = (rd_addr_r != cnt_r);
      end
      ST_FINISH: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Message bookkeeping. The opening '@' is stored at address 0; a later
  // '@' is an ordinary character, and the '#' itself is never stored.
  always_comb begin
    cnt_nxt   = cnt_r;
    split_nxt = split_r;
    dash_nxt  = dash_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r;
    if (accept && (state_r == ST_IDLE) && is_at) begin
      wr_en     = 1'b1;
      wr_addr   = '0;
      cnt_nxt   = CNT_W'(1);
      split_nxt = '0;
      dash_nxt  = 1'b0;
    end else if (accept && (state_r == ST_RECV) && !is_hash) begin
      wr_en   = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
      if (is_dash) begin
        // The last dash wins, so later ones move the split point.
        split_nxt = cnt_r;
        dash_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      split_r <= '0;
      dash_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      split_r <= split_nxt;
      dash_r  <= dash_nxt;
    end
  end

  // Message memory: one write port while collecting, one registered read
  // port while scanning.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      p_vld_r   <= 1'b0;
    end else if (scan_clr) begin
      rd_addr_r <= '0;
      p_vld_r   <= 1'b0;
    end else begin
      p_vld_r <= issue;
      if (issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx_r <= rd_addr_r;
    end
  end

  assign step.clr = scan_clr;
  assign step.vld = p_vld_r;

  sckp_match u_match (
    .clk      (clk),
    .ctl      (step),
    .byte_in  (rd_data_r),
    .idx      (p_idx_r),
    .split    (split_r),
    .dash     (dash_r),
    .found    (m_found),
    .command  (m_command),
    .argument (m_argument)
  );

  // Output register: the result waits here until its transfer completes,
  // while the next message is already being collected.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r    <= m_found;
      out_command_r  <= m_command;
      out_argument_r <= m_argument;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_command  = out_command_r;
  assign out_argument = out_argument_r;

  `SCKP_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_r == ST_RECV, cnt_r < CNT_LAST, "count overrun while collecting")
  `SCKP_ASSERT_IMPL(a_split_inside, clk, rst_n, dash_r && (state_r != ST_IDLE), split_r < cnt_r, "split point outside the message")
  `SCKP_ASSERT_IMPL(a_cmd_range, clk, rst_n, out_valid_r && out_found_r, out_command_r < CMD_W'(KEY_COUNT), "found command out of range")
  `SCKP_ASSERT_NEXT(a_hash_ends, clk, rst_n, accept && (state_r == ST_RECV) && is_hash, state_r == ST_SCAN, "terminator did not start the scan")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the serial command keyword parser. Bytes go in over a
// valid/ready channel and a scoreboard class works out the parse result of
// every framed message as each byte is transferred. Results coming out are
// compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------

module tb;

  localparam int STORE_DEPTH     = sckp_pkg::BUFFER_DEPTH;
  localparam int KEYWORD_COUNT   = 6;
  localparam int BYTES_PER_PHASE = 620;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam logic [7:0] CHR_AT   = 8'h40;
  localparam logic [7:0] CHR_DASH = 8'h2D;
  localparam logic [7:0] CHR_HASH = 8'h23;
  localparam logic [7:0] CHR_ZERO = 8'h30;

  // Keyword indexes as they appear on out_command.
  typedef enum logic [sckp_pkg::CMD_W-1:0] {
    CMD_RGB,
    CMD_LCD,
    CMD_RELAY_ON,
    CMD_RELAY_OFF,
    CMD_MOTOR_ON,
    CMD_MOTOR_OFF
  } command_t;

  typedef struct packed {
    logic                       found;
    logic [sckp_pkg::CMD_W-1:0] command;
    logic [7:0]                 argument;
  } parse_result_t;

  // Keyword text including the leading '@', as it sits in the message.
  function automatic string keyword_text(command_t c);
    case (c)
      CMD_RGB:       return "@rgb";
      CMD_LCD:       return "@lcd";
      CMD_RELAY_ON:  return "@relayON";
      CMD_RELAY_OFF: return "@relayOFF";
      CMD_MOTOR_ON:  return "@motorON";
      default:       return "@motorOFF";
    endcase
  endfunction

  // Tracks the framing state of the byte stream and queues the result that
  // each completed message has to produce.
  class keyword_scoreboard;
    bit            receiving;
    int            char_count;
    logic [7:0]    msg_bytes [STORE_DEPTH];
    int            dash_pos;
    bit            dash_seen;
    parse_result_t expected_q [$];
    int            errors;
    int            parsed_bytes;

    function new();
      receiving    = 0;
      char_count   = 0;
      dash_pos     = 0;
      dash_seen    = 0;
      errors       = 0;
      parsed_bytes = 0;
    endfunction

    function void close_message();
      parse_result_t r;
      string         kw;
      bit            name_match;
      r = '0;
      if (dash_seen && dash_pos < char_count) begin
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
          kw = keyword_text(command_t'(k));
          if (!r.found && kw.len() == dash_pos) begin
            name_match = 1;
            for (int j = 0; j < dash_pos; j++) begin
              if (msg_bytes[j] != kw[j]) begin
                name_match = 0;
              end
            end
            if (name_match) begin
              r.found   = 1'b1;
              r.command = k[sckp_pkg::CMD_W-1:0];
            end
          end
        end
        // Everything after the last dash folds as decimal, unchecked, mod 256.
        for (int j = dash_pos + 1; j < char_count; j++) begin
          r.argument = 8'(r.argument * 10 + msg_bytes[j] - CHR_ZERO);
        end
      end
      expected_q.push_back(r);
      receiving  = 0;
      char_count = 0;
      dash_pos   = 0;
      dash_seen  = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      if (!receiving) begin
        if (b != CHR_AT) begin
          return;
        end
        receiving  = 1;
        char_count = 0;
        dash_pos   = 0;
        dash_seen  = 0;
      end
      parsed_bytes++;
      if (b == CHR_HASH) begin
        close_message();
        return;
      end
      if (b == CHR_DASH) begin
        dash_pos  = char_count;
        dash_seen = 1;
      end
      msg_bytes[char_count] = b;
      char_count++;
      if (char_count == STORE_DEPTH - 1) begin
        close_message();
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: found %0d command %0d argument %0d",
               got.found, got.command, got.argument);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.command !== want.command) begin
        $error("command: expected %0d, actual %0d", want.command, got.command);
        errors++;
      end
      if (got.argument !== want.argument) begin
        $error("argument: expected %0d, actual %0d", want.argument, got.argument);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_rx_byte = 8'h00;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_found;
  logic [sckp_pkg::CMD_W-1:0] out_command;
  logic [7:0]                 out_argument;

  // Idle percentages per channel; the stimulus process changes them per phase.
  int send_idle_pct = 28;
  int recv_idle_pct = 70;
  // A hold-off of the result side is requested by bumping this counter.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  keyword_scoreboard sb = new();

  always #5 clk = ~clk;

  serial_command_keyword_parser u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_command  (out_command),
    .out_argument (out_argument)
  );

  // Result side. Every transfer is checked against the scoreboard. The ready
  // line idles at random, except during a requested hold-off, which is counted
  // here so that the input side keeps offering bytes while results back up.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_found, out_command, out_argument});
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run that moves nothing on either channel for too long is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Offers one byte, with random idle cycles ahead of it, and waits for the
  // transfer. Returns at the clock edge at which the byte was taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Argument characters: mostly decimal digits, now and then any byte at all.
  function automatic void append_digits(ref logic [7:0] q [$], input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        q.push_back(8'($urandom_range(0, 255)));
      end else begin
        q.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
      end
    end
  endfunction

  // Builds one message and sends it. Most are keyword, dash, number, '#',
  // sometimes with a corrupted name or a doubled '@'. The rest have several
  // dashes, run into truncation, carry random content, or are idle noise.
  task automatic send_random_message();
    logic [7:0] msg [$];
    logic [7:0] b;
    int         kind;
    string      kw;
    kind = $urandom_range(0, 99);
    kw   = keyword_text(command_t'($urandom_range(0, KEYWORD_COUNT - 1)));
    if (kind < 85) begin
      for (int i = 0; i < kw.len(); i++) begin
        msg.push_back(kw[i]);
      end
    end
    if (kind < 55) begin
      if ($urandom_range(0, 9) == 0) begin
        msg[$urandom_range(1, msg.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 19) == 0) begin
        msg.push_front(CHR_AT);
      end
      msg.push_back(CHR_DASH);
      append_digits(msg, $urandom_range(0, 4));
      msg.push_back(CHR_HASH);
    end else if (kind < 70) begin
      // The name ends at the last dash, so this name never matches.
      msg.push_back(CHR_DASH);
      for (int i = $urandom_range(0, 2); i > 0; i--) begin
        msg.push_back(8'($urandom_range(0, 255)));
      end
      msg.push_back(CHR_DASH);
      append_digits(msg, $urandom_range(0, 3));
      msg.push_back(CHR_HASH);
    end else if (kind < 85) begin
      // Long enough to hit the store limit; the remaining digits are ignored.
      msg.push_back(CHR_DASH);
      append_digits(msg, STORE_DEPTH - 2 - kw.len() + $urandom_range(0, 3));
    end else if (kind < 93) begin
      msg.push_back(CHR_AT);
      for (int i = $urandom_range(0, 15); i > 0; i--) begin
        msg.push_back(8'($urandom_range(0, 255)));
      end
      msg.push_back(CHR_HASH);
    end else begin
      for (int i = $urandom_range(1, 5); i > 0; i--) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHR_AT) begin
          b = 8'hC0;
        end
        msg.push_back(b);
      end
    end
    foreach (msg[i]) begin
      send_byte(msg[i]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: idle noise, the empty message, a plain keyword, a name
    // with no dash, a message cut off at the store limit, and a message made
    // of zero bytes whose argument folds a non-digit.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("@#");
    send_text("@lcd-9#");
    send_text("@rgb#");
    send_text("@motorOFF-1234");
    send_byte(CHR_AT);
    send_byte(8'h00);
    send_byte(CHR_DASH);
    send_byte(8'h00);
    send_byte(CHR_HASH);

    // Sender mostly busy, receiver mostly stalled.
    while (sb.parsed_bytes < BYTES_PER_PHASE) begin
      send_random_message();
    end

    // Roles swapped.
    send_idle_pct = 70;
    recv_idle_pct = 28;
    while (sb.parsed_bytes < 2 * BYTES_PER_PHASE) begin
      send_random_message();
    end

    // Full rate on both sides, opened by a long receiver hold-off so the
    // parser fills up and has to push back on its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    while (sb.parsed_bytes < 3 * BYTES_PER_PHASE) begin
      send_random_message();
    end
    in_valid <= 1'b0;

    // Let every expected result drain, then give stray results time to show.
    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
